// ===== rtl/core/rbnp_pkg.sv =====
package rbnp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned IdW    = 16;
  localparam int unsigned TolW   = 31;
  localparam int unsigned NumW   = 49;
  localparam int unsigned QuoW   = 49;
  localparam int unsigned TW     = 34;
  localparam int unsigned CntW   = 6;

  localparam logic [TW-1:0] TMax = {2'b00, {32{1'b1}}};
  localparam logic [TW-1:0] TMin = {2'b11, 32'd0};

  localparam logic [2:0] RegOrgX = 3'd0;
  localparam logic [2:0] RegOrgY = 3'd1;
  localparam logic [2:0] RegOrgZ = 3'd2;
  localparam logic [2:0] RegDirX = 3'd3;
  localparam logic [2:0] RegDirY = 3'd4;
  localparam logic [2:0] RegDirZ = 3'd5;
  localparam logic [2:0] RegTol  = 3'd6;

  typedef struct packed {
    logic load;
    logic set_axis;
    logic [1:0] axis;
    logic sel_hi;
    logic div_start;
    logic take_t1;
    logic take_t2;
    logic update_best;
    logic emit;
  } rbnp_cmd_t;

  typedef struct packed {
    logic box_ok;
    logic parallel;
    logic par_in;
    logic div_done;
    logic slab_ok;
    logic last;
  } rbnp_sts_t;

endpackage

// ===== rtl/core/rbnp_box_if.sv =====
interface rbnp_box_if;
  logic valid;
  logic ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic visible;
  logic [15:0] body_id;
  logic last_item;
  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, visible, body_id, last_item, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, visible, body_id, last_item, output ready);
endinterface

// ===== rtl/core/rbnp_hit_if.sv =====
interface rbnp_hit_if;
  logic valid;
  logic ready;
  logic hit;
  logic [15:0] hit_body_id;
  logic [31:0] hit_distance;
  modport source (output valid, hit, hit_body_id, hit_distance, input ready);
  modport sink (input valid, hit, hit_body_id, hit_distance, output ready);
endinterface

// ===== rtl/core/rbnp_divider.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module rbnp_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rbnp_pkg::NumW-1:0]   num,
  input  logic signed [rbnp_pkg::CoordW-1:0] den,
  output logic                               done,
  output logic signed [rbnp_pkg::QuoW-1:0]   quo
);
  localparam int unsigned N = rbnp_pkg::NumW;
  logic [N-1:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] d_r, d_nxt;
  logic neg_r, neg_nxt;
  logic [rbnp_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[N-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = num[N-1] ? N'(-num) : N'(num);
      d_nxt = den[31] ? 33'(-{den[31], den}) : {1'b0, den};
      rem_nxt = '0;
      neg_nxt = num[N-1] ^ den[31];
      cnt_nxt = rbnp_pkg::CntW'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt = {q_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[N-1]};
        q_nxt = {q_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rbnp_pkg::CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// ===== rtl/core/rbnp_datapath.sv =====
module rbnp_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rbnp_pkg::rbnp_cmd_t                cmd,
  output rbnp_pkg::rbnp_sts_t                sts,
  rbnp_box_if.sink                           box,
  input  logic signed [rbnp_pkg::CoordW-1:0] org [3],
  input  logic signed [rbnp_pkg::CoordW-1:0] dir [3],
  input  logic [rbnp_pkg::TolW-1:0]          tol,
  output logic                               res_hit,
  output logic [rbnp_pkg::IdW-1:0]           res_id,
  output logic [rbnp_pkg::CoordW-1:0]        res_dist
);
  localparam int unsigned TW = rbnp_pkg::TW;
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic [15:0] id_r;
  logic last_r, vis_r;
  logic [1:0] ax_r;
  logic signed [TW-1:0] t1_r, enter_r, leave_r;
  logic best_valid_r;
  logic [31:0] best_dist_r;
  logic [15:0] best_body_r;
  logic hit_r;
  logic [15:0] rid_r;
  logic [31:0] rdist_r;

  logic signed [31:0] o, d, b;
  logic signed [32:0] mag;
  logic signed [32:0] diff;
  logic signed [rbnp_pkg::NumW-1:0] num;
  logic div_done;
  logic signed [rbnp_pkg::QuoW-1:0] quo;
  logic signed [TW-1:0] tq, tlo, thi, en_n, lv_n;

  assign o = org[ax_r];
  assign d = dir[ax_r];
  assign b = cmd.sel_hi ? hi_r[ax_r] : lo_r[ax_r];
  assign mag = d[31] ? -33'(d) : 33'(d);
  assign diff = 33'(b) - 33'(o);
  assign num = {diff, 16'd0};

  rbnp_divider u_div (.clk, .rst_n, .start(cmd.div_start), .num, .den(d),
                      .done(div_done), .quo);

  always_comb begin
    if (quo > $signed({15'd0, rbnp_pkg::TMax})) tq = rbnp_pkg::TMax;
    else if (quo < $signed({{15{1'b1}}, rbnp_pkg::TMin})) tq = rbnp_pkg::TMin;
    else tq = quo[TW-1:0];
    tlo = (t1_r > tq) ? tq : t1_r;
    thi = (t1_r > tq) ? t1_r : tq;
    en_n = (tlo > enter_r) ? tlo : enter_r;
    lv_n = (thi < leave_r) ? thi : leave_r;
  end

  assign box.ready = cmd.load;
  assign sts.box_ok = vis_r && lo_r[0] <= hi_r[0] && lo_r[1] <= hi_r[1] && lo_r[2] <= hi_r[2];
  assign sts.parallel = mag <= $signed({2'b00, tol});
  assign sts.par_in = o >= lo_r[ax_r] && o <= hi_r[ax_r];
  assign sts.div_done = div_done;
  assign sts.slab_ok = enter_r <= leave_r;
  assign sts.last = last_r;

  always_ff @(posedge clk) begin
    if (cmd.load && box.valid) begin
      lo_r[0] <= box.box_min_x; lo_r[1] <= box.box_min_y; lo_r[2] <= box.box_min_z;
      hi_r[0] <= box.box_max_x; hi_r[1] <= box.box_max_y; hi_r[2] <= box.box_max_z;
      id_r <= box.body_id; last_r <= box.last_item; vis_r <= box.visible;
      enter_r <= '0; leave_r <= rbnp_pkg::TMax;
    end
    if (cmd.set_axis) ax_r <= cmd.axis;
    if (cmd.take_t1) t1_r <= tq;
    if (cmd.take_t2) begin
      enter_r <= en_n;
      leave_r <= lv_n;
    end
    if (cmd.emit) begin
      hit_r <= best_valid_r; rid_r <= best_body_r; rdist_r <= best_dist_r;
    end
    if (!rst_n) begin
      best_valid_r <= 1'b0; best_dist_r <= '0; best_body_r <= '0;
    end else if (cmd.emit) begin
      best_valid_r <= 1'b0; best_dist_r <= '0; best_body_r <= '0;
    end else if (cmd.update_best && (!best_valid_r || enter_r[31:0] < best_dist_r)) begin
      best_valid_r <= 1'b1; best_dist_r <= enter_r[31:0]; best_body_r <= id_r;
    end
  end

  assign res_hit = hit_r;
  assign res_id = rid_r;
  assign res_dist = rdist_r;
endmodule

// ===== rtl/core/rbnp_ctrl.sv =====
module rbnp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_busy,
  input  rbnp_pkg::rbnp_sts_t sts,
  output rbnp_pkg::rbnp_cmd_t cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_AXIS  = 8'b00000100,
    S_DIV1  = 8'b00001000,
    S_DIV2  = 8'b00010000,
    S_NEXT  = 8'b00100000,
    S_BEST  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;
  state_t state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic first_r, first_nxt;

  always_comb begin
    state_nxt = state_r; ax_nxt = ax_r; first_nxt = first_r;
    cmd = '0;
    cmd.axis = ax_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = 1'b1;
        cmd.set_axis = 1'b1;
        cmd.axis = 2'd0;
        ax_nxt = 2'd0;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: state_nxt = sts.box_ok ? S_AXIS : S_EMIT;
      S_AXIS: begin
        if (sts.parallel) state_nxt = sts.par_in ? S_NEXT : S_EMIT;
        else begin
          cmd.div_start = 1'b1;
          first_nxt = 1'b1;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: if (sts.div_done) begin
        if (first_r) begin
          cmd.take_t1 = 1'b1;
          cmd.sel_hi = 1'b1;
          cmd.div_start = 1'b1;
          first_nxt = 1'b0;
        end else begin
          cmd.take_t2 = 1'b1;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: state_nxt = sts.slab_ok ? S_NEXT : S_EMIT;
      S_NEXT: begin
        if (ax_r == 2'd2) state_nxt = S_BEST;
        else begin
          ax_nxt = ax_r + 2'd1;
          cmd.set_axis = 1'b1;
          cmd.axis = ax_nxt;
          state_nxt = S_AXIS;
        end
      end
      S_BEST: begin
        cmd.update_best = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.last) state_nxt = S_IDLE;
        else if (!out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt; first_r <= first_nxt;
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== rtl/core/ray_box_nearest_pick_unit.sv =====
// Ray versus axis-aligned box nearest pick. Write the ray origin, direction and
// parallel tolerance over the APB port, then stream boxes on the in_ channel; on
// the beat flagged last_item one out_ beat gives hit, body id and entry distance
// (unsigned Q16.16) of the nearest box and the best is cleared. One box is taken
// at a time: a hidden or inverted box is dropped before any division, and a full
// hit runs through the single 49-step serial divider shared by all six slab
// quotients (each quotient takes 49 steps). A parallel axis skips its divisions.
// A result waits in an output register while the next box is processed.
module ray_box_nearest_pick_unit (
  input  logic        clk,
  input  logic        rst_n,
  rbnp_box_if.sink    in_box,
  rbnp_hit_if.source  out_hit,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];
  logic [30:0] tol_r;
  logic out_valid_r;
  rbnp_pkg::rbnp_cmd_t cmd;
  rbnp_pkg::rbnp_sts_t sts;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
      tol_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        rbnp_pkg::RegOrgX: org_r[0] <= cfg_pwdata;
        rbnp_pkg::RegOrgY: org_r[1] <= cfg_pwdata;
        rbnp_pkg::RegOrgZ: org_r[2] <= cfg_pwdata;
        rbnp_pkg::RegDirX: dir_r[0] <= cfg_pwdata;
        rbnp_pkg::RegDirY: dir_r[1] <= cfg_pwdata;
        rbnp_pkg::RegDirZ: dir_r[2] <= cfg_pwdata;
        rbnp_pkg::RegTol:  tol_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      rbnp_pkg::RegOrgX: cfg_prdata = org_r[0];
      rbnp_pkg::RegOrgY: cfg_prdata = org_r[1];
      rbnp_pkg::RegOrgZ: cfg_prdata = org_r[2];
      rbnp_pkg::RegDirX: cfg_prdata = dir_r[0];
      rbnp_pkg::RegDirY: cfg_prdata = dir_r[1];
      rbnp_pkg::RegDirZ: cfg_prdata = dir_r[2];
      rbnp_pkg::RegTol:  cfg_prdata = {1'b0, tol_r};
      default: cfg_prdata = '0;
    endcase
  end

  rbnp_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_box.valid),
                    .out_busy(out_valid_r && !out_hit.ready), .sts, .cmd);

  rbnp_datapath u_dp (.clk, .rst_n, .cmd, .sts, .box(in_box), .org(org_r), .dir(dir_r),
                      .tol(tol_r), .res_hit(out_hit.hit), .res_id(out_hit.hit_body_id),
                      .res_dist(out_hit.hit_distance));

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_hit.ready) out_valid_r <= 1'b0;
  end
  assign out_hit.valid = out_valid_r;
endmodule
